[rtl/ewt_pkg.sv]
`timescale 1ns / 1ps

package ewt_pkg;

    // Fixed field widths at the ports
    localparam int SLOT_W = 5;
    localparam int NODE_W = 8;
    localparam int KIND_W = 2;
    localparam int WALK_W = 6;
    localparam int ACT_W  = 2;

    // Compare width for slot / count checks (covers counts up to 127)
    localparam int CMP_W  = 7;

    localparam logic [WALK_W-1:0] WALK_MAX = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_START  = 2'd1,
        ACT_CHOOSE = 2'd2
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CAND   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH,
        ST_REJECT
    } state_t;

    // Result of the shared incidence compare
    typedef struct packed {
        logic hit;     // unvisited and touches the node
        logic take_b;  // end_a is the node, so the far end is end_b
    } match_t;

endpackage

[rtl/ewt_match.sv]
`timescale 1ns / 1ps

module ewt_match #(
    parameter int NW = 8
) (
    input  logic [NW-1:0]       end_a,
    input  logic [NW-1:0]       end_b,
    input  logic [NW-1:0]       node,
    input  logic                visited,
    output ewt_pkg::match_t     res
);

    logic a_eq;
    logic b_eq;

    assign a_eq       = (end_a == node);
    assign b_eq       = (end_b == node);
    assign res.hit    = !visited && (a_eq || b_eq);
    assign res.take_b = a_eq;

endmodule

[rtl/ewt_edge_mem.sv]
`timescale 1ns / 1ps

module ewt_edge_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] store_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ewt_ctrl.sv]
`timescale 1ns / 1ps

module ewt_ctrl #(
    parameter int MAX_EDGES = 32,
    parameter int NODE_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ewt_pkg::ACT_W-1:0]           action,
    input  logic [ewt_pkg::SLOT_W-1:0]          edge_slot,
    input  logic [ewt_pkg::NODE_W-1:0]          node_first,
    input  logic [ewt_pkg::NODE_W-1:0]          node_second,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ewt_pkg::KIND_W-1:0]          kind,
    output logic [ewt_pkg::SLOT_W-1:0]          edge_index,
    output logic [ewt_pkg::NODE_W-1:0]          end_a,
    output logic [ewt_pkg::NODE_W-1:0]          end_b,
    output logic [ewt_pkg::NODE_W-1:0]          here_node,
    output logic [ewt_pkg::WALK_W-1:0]          walked_count,
    output logic                                last,

    output logic                                mem_we,
    output logic [$clog2(MAX_EDGES)-1:0]        mem_waddr,
    output logic [2*((NODE_BITS < ewt_pkg::NODE_W) ? NODE_BITS : ewt_pkg::NODE_W)-1:0]
                                                mem_wdata,
    output logic                                mem_re,
    output logic [$clog2(MAX_EDGES)-1:0]        mem_raddr,
    input  logic [2*((NODE_BITS < ewt_pkg::NODE_W) ? NODE_BITS : ewt_pkg::NODE_W)-1:0]
                                                mem_rdata
);

    localparam int IW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int NW = (NODE_BITS < ewt_pkg::NODE_W) ? NODE_BITS : ewt_pkg::NODE_W;
    localparam int XW = ewt_pkg::CMP_W;

    ewt_pkg::state_t            state_reg;
    ewt_pkg::state_t            state_next;

    logic [CW-1:0]              loaded_reg;
    logic [NW-1:0]              here_reg;
    logic [ewt_pkg::WALK_W-1:0] walk_reg;
    logic [MAX_EDGES-1:0]       visited_reg;

    logic [CW-1:0]              issue_reg;
    logic [IW-1:0]              eval_idx_reg;
    logic                       eval_vld_reg;

    logic                       held_vld_reg;
    logic [IW-1:0]              held_idx_reg;
    logic [NW-1:0]              held_a_reg;
    logic [NW-1:0]              held_b_reg;

    logic                       out_valid_reg;
    ewt_pkg::kind_t             out_kind_reg;
    logic [ewt_pkg::SLOT_W-1:0] out_idx_reg;
    logic [ewt_pkg::NODE_W-1:0] out_a_reg;
    logic [ewt_pkg::NODE_W-1:0] out_b_reg;
    logic [ewt_pkg::NODE_W-1:0] out_here_reg;
    logic [ewt_pkg::WALK_W-1:0] out_walk_reg;
    logic                       out_last_reg;

    logic [NW-1:0]              cur_a;
    logic [NW-1:0]              cur_b;
    ewt_pkg::match_t            m;

    logic                       can_push;
    logic [IW-1:0]              slot_idx;
    logic                       slot_fits;
    logic                       slot_loaded;
    logic [XW-1:0]              slot_plus;
    logic                       issue_more;
    logic                       scan_hit;

    logic                       do_load;
    logic                       start_scan;
    logic                       take_choice;
    logic                       choose_acc;
    logic                       scan_adv;
    logic                       hold_new;
    logic                       push;
    logic                       push_held;
    logic                       push_last;
    ewt_pkg::kind_t             push_kind;

    assign cur_a = mem_rdata[2*NW-1:NW];
    assign cur_b = mem_rdata[NW-1:0];

    // Shared incidence compare: choice check and every scan step
    ewt_match #(
        .NW (NW)
    ) u_match (
        .end_a   (cur_a),
        .end_b   (cur_b),
        .node    (here_reg),
        .visited (visited_reg[eval_idx_reg]),
        .res     (m)
    );

    assign can_push    = !out_valid_reg || out_ready;
    assign slot_idx    = IW'(edge_slot);
    assign slot_fits   = XW'(edge_slot) < XW'(MAX_EDGES);
    assign slot_loaded = XW'(edge_slot) < XW'(loaded_reg);
    assign slot_plus   = XW'(edge_slot) + XW'(1);
    assign issue_more  = issue_reg < loaded_reg;
    assign scan_hit    = eval_vld_reg && m.hit;

    assign mem_waddr   = slot_idx;
    assign mem_wdata   = {NW'(node_first), NW'(node_second)};

    assign in_ready    = (state_reg == ewt_pkg::ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = eval_idx_reg;
        do_load     = 1'b0;
        start_scan  = 1'b0;
        take_choice = 1'b0;
        choose_acc  = 1'b0;
        scan_adv    = 1'b0;
        hold_new    = 1'b0;
        push        = 1'b0;
        push_held   = 1'b0;
        push_last   = 1'b0;
        push_kind   = ewt_pkg::KIND_CAND;

        case (state_reg)
            ewt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        ewt_pkg::ACT_LOAD:
                        begin
                            do_load = slot_fits;
                            mem_we  = slot_fits;
                        end
                        ewt_pkg::ACT_START:
                        begin
                            start_scan = 1'b1;
                            state_next = ewt_pkg::ST_SCAN;
                        end
                        ewt_pkg::ACT_CHOOSE:
                        begin
                            choose_acc = 1'b1;
                            if (slot_loaded)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = slot_idx;
                                state_next = ewt_pkg::ST_CHECK;
                            end
                            else
                            begin
                                state_next = ewt_pkg::ST_REJECT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ewt_pkg::ST_CHECK:
            begin
                if (m.hit)
                begin
                    take_choice = 1'b1;
                    state_next  = ewt_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = ewt_pkg::ST_REJECT;
                end
            end

            ewt_pkg::ST_SCAN:
            begin
                // a new hit needs the held one moved out first
                if (!(scan_hit && held_vld_reg && !can_push))
                begin
                    if (scan_hit)
                    begin
                        hold_new  = 1'b1;
                        push      = held_vld_reg;
                        push_held = 1'b1;
                    end
                    if (issue_more)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = issue_reg[IW-1:0];
                    end
                    scan_adv = 1'b1;
                    if (!eval_vld_reg && !issue_more)
                    begin
                        state_next = ewt_pkg::ST_FINISH;
                    end
                end
            end

            ewt_pkg::ST_FINISH:
            begin
                if (can_push)
                begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    push_held = held_vld_reg;
                    push_kind = held_vld_reg ? ewt_pkg::KIND_CAND : ewt_pkg::KIND_EMPTY;
                    state_next = ewt_pkg::ST_IDLE;
                end
            end

            ewt_pkg::ST_REJECT:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    push_kind  = ewt_pkg::KIND_REJECT;
                    state_next = ewt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ewt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ewt_pkg::ST_IDLE;
            loaded_reg    <= '0;
            here_reg      <= '0;
            walk_reg      <= '0;
            visited_reg   <= '0;
            issue_reg     <= '0;
            eval_vld_reg  <= 1'b0;
            held_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (do_load)
            begin
                visited_reg[slot_idx] <= 1'b0;
                if (slot_plus > XW'(loaded_reg))
                begin
                    loaded_reg <= CW'(slot_plus);
                end
            end

            if (start_scan)
            begin
                here_reg <= NW'(node_first);
                walk_reg <= '0;
            end

            if (take_choice)
            begin
                visited_reg[eval_idx_reg] <= 1'b1;
                here_reg <= m.take_b ? cur_b : cur_a;
                if (walk_reg != ewt_pkg::WALK_MAX)
                begin
                    walk_reg <= walk_reg + 1'b1;
                end
            end

            if (start_scan || take_choice)
            begin
                issue_reg    <= '0;
                eval_vld_reg <= 1'b0;
                held_vld_reg <= 1'b0;
            end
            else
            begin
                if (scan_adv)
                begin
                    eval_vld_reg <= issue_more;
                    if (issue_more)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                end
                if (hold_new)
                begin
                    held_vld_reg <= 1'b1;
                end
                else if (push && state_reg == ewt_pkg::ST_FINISH)
                begin
                    held_vld_reg <= 1'b0;
                end
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (choose_acc)
        begin
            eval_idx_reg <= slot_idx;
        end
        else if (scan_adv)
        begin
            eval_idx_reg <= issue_reg[IW-1:0];
        end

        if (hold_new)
        begin
            held_idx_reg <= eval_idx_reg;
            held_a_reg   <= cur_a;
            held_b_reg   <= cur_b;
        end

        if (push)
        begin
            out_kind_reg <= push_kind;
            out_here_reg <= ewt_pkg::NODE_W'(here_reg);
            out_walk_reg <= walk_reg;
            out_last_reg <= push_last;
            if (push_held)
            begin
                out_idx_reg <= ewt_pkg::SLOT_W'(held_idx_reg);
                out_a_reg   <= ewt_pkg::NODE_W'(held_a_reg);
                out_b_reg   <= ewt_pkg::NODE_W'(held_b_reg);
            end
            else
            begin
                out_idx_reg <= '0;
                out_a_reg   <= '0;
                out_b_reg   <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign edge_index   = out_idx_reg;
    assign end_a        = out_a_reg;
    assign end_b        = out_b_reg;
    assign here_node    = out_here_reg;
    assign walked_count = out_walk_reg;
    assign last         = out_last_reg;

endmodule

[rtl/graph_edge_walk_tracker.sv]
`timescale 1ns / 1ps

// Edge-walk tracker. Holds a table of up to MAX_EDGES undirected edges, each
// with a visited mark, and a walker that sits on one node. An input word is
// a load (write an edge, clear its mark; no result), a start (place the
// walker, zero the walk count) or a choose (move along one unvisited edge
// that touches the walker's node). After a start or an accepted choose the
// block scans the loaded part of the table in index order and returns one
// word per unvisited incident edge, or a single "no edges left" word; the
// final word of each listing has last set. A rejected choose returns one
// reject word and changes nothing. A start or an accepted choose holds the
// block until its listing is done; the scan reads one table entry per cycle,
// unless a slow consumer stalls it, through the single read port of the edge
// memory and tests it on the one shared compare unit. Only one word is
// worked on at a time, and in_ready is high only between words. The
// finished result sits in an output register, so the next input word can
// be taken while it waits. Node values are kept to their low NODE_BITS bits.
// The edge memory is not cleared at reset; the user must load an entry
// before it is read, and the block itself does not enforce this.
module graph_edge_walk_tracker #(
    parameter int MAX_EDGES = 32,
    parameter int NODE_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ewt_pkg::ACT_W-1:0]   action,
    input  logic [ewt_pkg::SLOT_W-1:0]  edge_slot,
    input  logic [ewt_pkg::NODE_W-1:0]  node_first,
    input  logic [ewt_pkg::NODE_W-1:0]  node_second,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ewt_pkg::KIND_W-1:0]  kind,
    output logic [ewt_pkg::SLOT_W-1:0]  edge_index,
    output logic [ewt_pkg::NODE_W-1:0]  end_a,
    output logic [ewt_pkg::NODE_W-1:0]  end_b,
    output logic [ewt_pkg::NODE_W-1:0]  here_node,
    output logic [ewt_pkg::WALK_W-1:0]  walked_count,
    output logic                        last
);

    // Table index and stored node widths
    localparam int IW = $clog2(MAX_EDGES);
    localparam int NW = (NODE_BITS < ewt_pkg::NODE_W) ? NODE_BITS : ewt_pkg::NODE_W;
    localparam int MW = 2 * NW;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [MW-1:0] mem_rdata;

    // Sequencer: decode, choice check, scan, result register
    ewt_ctrl #(
        .MAX_EDGES (MAX_EDGES),
        .NODE_BITS (NODE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .edge_slot    (edge_slot),
        .node_first   (node_first),
        .node_second  (node_second),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .edge_index   (edge_index),
        .end_a        (end_a),
        .end_b        (end_b),
        .here_node    (here_node),
        .walked_count (walked_count),
        .last         (last),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    // Endpoint table: {end_a, end_b} per entry, registered read
    ewt_edge_mem #(
        .DEPTH (MAX_EDGES),
        .AW    (IW),
        .DW    (MW)
    ) u_edge_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

[rtl/ewt_checker.sv]
`timescale 1ns / 1ps

module ewt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [ewt_pkg::KIND_W-1:0]  kind,
    input logic [ewt_pkg::SLOT_W-1:0]  edge_index,
    input logic [ewt_pkg::NODE_W-1:0]  end_a,
    input logic [ewt_pkg::NODE_W-1:0]  end_b,
    input logic [ewt_pkg::NODE_W-1:0]  here_node,
    input logic                        last
);

    // Stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(edge_index)
            && $stable(end_a) && $stable(end_b) && $stable(last))
        else $error("result word changed while stalled");

    // Status words carry no edge
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != ewt_pkg::KIND_CAND
            |-> edge_index == '0 && end_a == '0 && end_b == '0)
        else $error("status word with edge fields");

    // Status words close their listing
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == ewt_pkg::KIND_EMPTY || kind == ewt_pkg::KIND_REJECT) |-> last)
        else $error("status word without last");

    // Every candidate touches the walker's node
    a_cand_incident: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == ewt_pkg::KIND_CAND |-> end_a == here_node || end_b == here_node)
        else $error("candidate not incident to current node");

endmodule

bind graph_edge_walk_tracker ewt_checker u_ewt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .edge_index (edge_index),
    .end_a      (end_a),
    .end_b      (end_b),
    .here_node  (here_node),
    .last       (last)
);

[tb/sv/graph_edge_walk_tracker_tb.sv]
`timescale 1ns / 1ps

module graph_edge_walk_tracker_tb;

    // Action code 3 has no meaning; the block drops such words silently.
    localparam logic [ewt_pkg::ACT_W-1:0] ACT_NONE = 2'd3;

    localparam int TABLE_SIZE  = 32;
    localparam int WORD_TARGET = 470;
    // Limit from the worst case per word: a full scan, 32 results each
    // stalled by the consumer, plus a sender gap, times ~600 words, then
    // taken several times over.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Settle time at the end: longest scan over a full table plus margin.
    localparam int DRAIN_CYCLES = 80;

    // Shadow copy of everything the block keeps.
    typedef struct packed {
        logic [TABLE_SIZE-1:0][ewt_pkg::NODE_W-1:0] ea;       // first endpoints
        logic [TABLE_SIZE-1:0][ewt_pkg::NODE_W-1:0] eb;       // second endpoints
        logic [TABLE_SIZE-1:0]                      visited;
        logic [ewt_pkg::WALK_W-1:0]                 loaded;   // 0..32
        logic [ewt_pkg::NODE_W-1:0]                 here;     // walker position
        logic [ewt_pkg::WALK_W-1:0]                 walks;    // edges walked since start
    } tracker_state_t;

    // Field order matches {action, edge_slot, node_first, node_second}.
    typedef struct packed {
        logic [ewt_pkg::ACT_W-1:0]  act;
        logic [ewt_pkg::SLOT_W-1:0] slot;
        logic [ewt_pkg::NODE_W-1:0] n1;
        logic [ewt_pkg::NODE_W-1:0] n2;
    } tracker_word_t;

    typedef struct packed {
        ewt_pkg::kind_t             kind;
        logic [ewt_pkg::SLOT_W-1:0] idx;
        logic [ewt_pkg::NODE_W-1:0] a;
        logic [ewt_pkg::NODE_W-1:0] b;
        logic [ewt_pkg::NODE_W-1:0] here;
        logic [ewt_pkg::WALK_W-1:0] walked;
        logic                       last;
    } tracker_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic [ewt_pkg::ACT_W-1:0]  action      = '0;
    logic [ewt_pkg::SLOT_W-1:0] edge_slot   = '0;
    logic [ewt_pkg::NODE_W-1:0] node_first  = '0;
    logic [ewt_pkg::NODE_W-1:0] node_second = '0;

    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic [ewt_pkg::KIND_W-1:0] kind;
    logic [ewt_pkg::SLOT_W-1:0] edge_index;
    logic [ewt_pkg::NODE_W-1:0] end_a;
    logic [ewt_pkg::NODE_W-1:0] end_b;
    logic [ewt_pkg::NODE_W-1:0] here_node;
    logic [ewt_pkg::WALK_W-1:0] walked_count;
    logic                       last;

    graph_edge_walk_tracker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .edge_slot    (edge_slot),
        .node_first   (node_first),
        .node_second  (node_second),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .edge_index   (edge_index),
        .end_a        (end_a),
        .end_b        (end_b),
        .here_node    (here_node),
        .walked_count (walked_count),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Walk prediction
    // ------------------------------------------------------------------

    tracker_state_t  model = '0;        // follows accepted words
    tracker_state_t  plan  = '0;        // follows generated words
    tracker_result_t expected_listing[$];
    int              mismatches = 0;

    // Unvisited and incident to the walker's node.
    function automatic bit touches(tracker_state_t st, int i);
        return !st.visited[i] && (st.ea[i] == st.here || st.eb[i] == st.here);
    endfunction

    function automatic bit move_ok(tracker_state_t st, logic [ewt_pkg::SLOT_W-1:0] slot);
        return (ewt_pkg::WALK_W'(slot) < st.loaded) && touches(st, slot);
    endfunction

    function automatic tracker_state_t next_state(tracker_state_t st, tracker_word_t w);
        tracker_state_t nx;
        nx = st;
        case (w.act)
            ewt_pkg::ACT_LOAD:
            begin
                nx.ea[w.slot]      = w.n1;
                nx.eb[w.slot]      = w.n2;
                nx.visited[w.slot] = 1'b0;
                if (ewt_pkg::WALK_W'(w.slot) + 6'd1 > st.loaded)
                    nx.loaded = ewt_pkg::WALK_W'(w.slot) + 6'd1;
            end
            ewt_pkg::ACT_START:
            begin
                nx.here  = w.n1;
                nx.walks = '0;
            end
            ewt_pkg::ACT_CHOOSE:
            begin
                if (move_ok(st, w.slot))
                begin
                    nx.visited[w.slot] = 1'b1;
                    if (st.walks != ewt_pkg::WALK_MAX)
                        nx.walks = st.walks + 6'd1;
                    // a self-loop leaves the walker where it is
                    nx.here = (st.ea[w.slot] == st.here) ? st.eb[w.slot] : st.ea[w.slot];
                end
            end
            default:
            begin
            end
        endcase
        return nx;
    endfunction

    // Queues the words that one accepted input word should produce and
    // advances the model.
    function automatic void predict_listing(tracker_word_t w);
        tracker_state_t  nx;
        tracker_result_t r;
        int              hits;
        nx   = next_state(model, w);
        r    = '0;
        hits = 0;
        if (w.act == ewt_pkg::ACT_START ||
            (w.act == ewt_pkg::ACT_CHOOSE && move_ok(model, w.slot)))
        begin
            r.here   = nx.here;
            r.walked = nx.walks;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                if (i < int'(nx.loaded) && touches(nx, i))
                begin
                    r.kind = ewt_pkg::KIND_CAND;
                    r.idx  = i[ewt_pkg::SLOT_W-1:0];
                    r.a    = nx.ea[i];
                    r.b    = nx.eb[i];
                    expected_listing.push_back(r);
                    hits++;
                end
            end
            if (hits == 0)
            begin
                r      = '0;
                r.kind = ewt_pkg::KIND_EMPTY;
                r.here = nx.here;
                r.walked = nx.walks;
                expected_listing.push_back(r);
            end
            r      = expected_listing.pop_back();
            r.last = 1'b1;
            expected_listing.push_back(r);
        end
        else if (w.act == ewt_pkg::ACT_CHOOSE)
        begin
            r.kind   = ewt_pkg::KIND_REJECT;
            r.here   = model.here;
            r.walked = model.walks;
            r.last   = 1'b1;
            expected_listing.push_back(r);
        end
        model = nx;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    tracker_word_t              stimulus_words[$];
    int                         real_words = 0;   // words the block does not ignore
    logic [ewt_pkg::NODE_W-1:0] node_pool[8];
    int                         pool_size = 2;

    function automatic void add_word(logic [ewt_pkg::ACT_W-1:0] act,
                                     logic [ewt_pkg::SLOT_W-1:0] slot,
                                     logic [ewt_pkg::NODE_W-1:0] n1,
                                     logic [ewt_pkg::NODE_W-1:0] n2);
        tracker_word_t w;
        w = '{act: act, slot: slot, n1: n1, n2: n2};
        stimulus_words.push_back(w);
        plan = next_state(plan, w);
        if (act != ACT_NONE)
            real_words++;
    endfunction

    // Mostly nodes of the current pool, now and then any node at all.
    function automatic logic [ewt_pkg::NODE_W-1:0] pool_node();
        if ($urandom_range(0, 9) == 0)
            return ewt_pkg::NODE_W'($urandom);
        return node_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    // Loads only overwrite a loaded slot or extend the table by one, so no
    // unwritten entry ever falls below the loaded count.
    function automatic logic [ewt_pkg::SLOT_W-1:0] load_slot();
        int hi;
        hi = (int'(plan.loaded) > TABLE_SIZE - 1) ? TABLE_SIZE - 1 : int'(plan.loaded);
        return ewt_pkg::SLOT_W'($urandom_range(0, hi));
    endfunction

    task automatic walk_episode();
        int picks[$];
        int steps;
        int roll;
        pool_size = $urandom_range(2, 8);
        for (int k = 0; k < pool_size; k++)
        begin
            case ($urandom_range(0, 9))
                0:       node_pool[k] = '0;
                1:       node_pool[k] = '1;
                default: node_pool[k] = ewt_pkg::NODE_W'($urandom);
            endcase
        end
        repeat ($urandom_range(1, 6))
            add_word(ewt_pkg::ACT_LOAD, load_slot(), pool_node(), pool_node());
        add_word(ewt_pkg::ACT_START, ewt_pkg::SLOT_W'($urandom), pool_node(),
                 ewt_pkg::NODE_W'($urandom));
        steps = $urandom_range(1, 14);
        repeat (steps)
        begin
            picks.delete();
            for (int i = 0; i < int'(plan.loaded); i++)
                if (touches(plan, i))
                    picks.push_back(i);
            roll = $urandom_range(0, 99);
            if (roll < 70 && picks.size() > 0)
                add_word(ewt_pkg::ACT_CHOOSE,
                         ewt_pkg::SLOT_W'(picks[$urandom_range(0, picks.size() - 1)]),
                         ewt_pkg::NODE_W'($urandom), ewt_pkg::NODE_W'($urandom));
            else if (roll < 82 || roll < 70)
                add_word(ewt_pkg::ACT_CHOOSE, ewt_pkg::SLOT_W'($urandom),
                         ewt_pkg::NODE_W'($urandom), ewt_pkg::NODE_W'($urandom));
            else if (roll < 90)
                add_word(ewt_pkg::ACT_LOAD, load_slot(), pool_node(), pool_node());
            else if (roll < 95)
                add_word(ACT_NONE, ewt_pkg::SLOT_W'($urandom),
                         ewt_pkg::NODE_W'($urandom), ewt_pkg::NODE_W'($urandom));
            else
                add_word(ewt_pkg::ACT_START, ewt_pkg::SLOT_W'($urandom), pool_node(),
                         ewt_pkg::NODE_W'($urandom));
        end
    endtask

    // The walk count only passes 32 when walked edges are reloaded: walk a
    // self-loop, reload it to clear its mark, and repeat past saturation.
    task automatic saturate_walk();
        logic [ewt_pkg::SLOT_W-1:0] s;
        logic [ewt_pkg::NODE_W-1:0] x;
        s = load_slot();
        x = ewt_pkg::NODE_W'($urandom);
        add_word(ewt_pkg::ACT_LOAD, s, x, x);
        add_word(ewt_pkg::ACT_START, ewt_pkg::SLOT_W'($urandom), x, ewt_pkg::NODE_W'($urandom));
        repeat (66)
        begin
            add_word(ewt_pkg::ACT_CHOOSE, s, ewt_pkg::NODE_W'($urandom),
                     ewt_pkg::NODE_W'($urandom));
            add_word(ewt_pkg::ACT_LOAD, s, x, x);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps between bursts
    // ------------------------------------------------------------------

    int            gap_left   = 0;
    int            burst_left = 1;
    tracker_word_t next_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_listing({action, edge_slot, node_first, node_second});
            // free to change the bus unless a word is still waiting
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stimulus_words.size() > 0)
                begin
                    next_word = stimulus_words.pop_front();
                    in_valid <= 1'b1;
                    {action, edge_slot, node_first, node_second} <= next_word;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: own stall pattern, compares each result word in order
    // ------------------------------------------------------------------

    logic [15:0]     stall_pattern = 16'h0001;
    bit              open_stretch  = 1'b1;   // no stalls at all for a while
    int              pattern_age   = 0;
    tracker_result_t want;

    function automatic void check_field(string what, logic [31:0] exp_val,
                                        logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_listing.size() == 0)
                begin
                    $display("%0t ns: unexpected result word, kind %0d index %0d",
                             $time, kind, edge_index);
                    mismatches++;
                end
                else
                begin
                    want = expected_listing.pop_front();
                    check_field("kind",         want.kind,   kind);
                    check_field("edge_index",   want.idx,    edge_index);
                    check_field("end_a",        want.a,      end_a);
                    check_field("end_b",        want.b,      end_b);
                    check_field("here_node",    want.here,   here_node);
                    check_field("walked_count", want.walked, walked_count);
                    check_field("last",         want.last,   last);
                end
            end
            // new pattern now and then; never all zero, so a stall ends
            if (pattern_age == 0)
            begin
                stall_pattern = 16'($urandom) | 16'h0001;
                open_stretch  = ($urandom_range(0, 2) == 0);
                pattern_age   = $urandom_range(50, 300);
            end
            else
            begin
                pattern_age--;
            end
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            out_ready <= open_stretch || stall_pattern[0];
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------

    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed words, a saturation run, then random walks
    // ------------------------------------------------------------------

    initial
    begin
        // choose and start on an empty table
        add_word(ewt_pkg::ACT_CHOOSE, 5'd0, 8'h00, 8'h00);
        add_word(ewt_pkg::ACT_START, 5'd0, 8'hFF, 8'hFF);
        add_word(ACT_NONE, 5'd31, 8'hFF, 8'hFF);
        // small graph with a self-loop at each end of the node range
        add_word(ewt_pkg::ACT_LOAD, 5'd0, 8'h00, 8'hFF);
        add_word(ewt_pkg::ACT_LOAD, 5'd1, 8'hFF, 8'hFF);
        add_word(ewt_pkg::ACT_LOAD, 5'd2, 8'h00, 8'h00);
        add_word(ewt_pkg::ACT_LOAD, 5'd3, 8'h80, 8'h01);
        add_word(ewt_pkg::ACT_LOAD, 5'd4, 8'hFF, 8'h00);
        add_word(ewt_pkg::ACT_START, 5'd31, 8'hFF, 8'h00);
        // rejects: not incident, past the loaded count, far slot
        add_word(ewt_pkg::ACT_CHOOSE, 5'd3, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));
        add_word(ewt_pkg::ACT_CHOOSE, 5'd5, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));
        add_word(ewt_pkg::ACT_CHOOSE, 5'd31, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));
        // self-loop, then the same edge again (visited)
        add_word(ewt_pkg::ACT_CHOOSE, 5'd1, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));
        add_word(ewt_pkg::ACT_CHOOSE, 5'd1, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));
        // walker matches end_b, moves to end_a
        add_word(ewt_pkg::ACT_CHOOSE, 5'd0, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));
        add_word(ewt_pkg::ACT_CHOOSE, 5'd2, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));
        add_word(ewt_pkg::ACT_CHOOSE, 5'd4, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));
        // restart keeps the marks
        add_word(ewt_pkg::ACT_START, 5'd0, 8'h01, 8'hAA);
        add_word(ewt_pkg::ACT_CHOOSE, 5'd3, 8'hFF, 8'hFF);
        // reload clears a mark
        add_word(ewt_pkg::ACT_LOAD, 5'd3, 8'h55, 8'hAA);
        add_word(ewt_pkg::ACT_LOAD, 5'd5, 8'hAA, 8'h80);
        add_word(ewt_pkg::ACT_START, 5'd0, 8'h80, 8'h00);
        add_word(ewt_pkg::ACT_CHOOSE, 5'd5, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));
        add_word(ewt_pkg::ACT_CHOOSE, 5'd3, ewt_pkg::NODE_W'($urandom),
                 ewt_pkg::NODE_W'($urandom));

        saturate_walk();
        while (real_words < WORD_TARGET)
            walk_episode();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (stimulus_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_listing.size() != 0)
            @(posedge clk);
        // catch stray words from a scan still running
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
